[design/two_link_leg_inverse_kinematics_assert.svh]
// Assertion macros for the leg inverse kinematics RTL (used by the queue).
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH

`ifndef SYNTH
`define TLIK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLIK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLIK_ASSERT(label, clk, rst_n, prop, msg)
`define TLIK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[design/tlik_pkg.sv]
// Shared types, constants and helpers of the leg inverse kinematics block.
package tlik_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS
                                                                    : ATAN_LEN;
  localparam int NORM_STAGES       = 6;
  localparam int CORDIC_LAT        = 1 + NORM_STAGES + CORDIC_STAGES;
  localparam int SQRT_STAGES       = 32;
  localparam int BACK_LAT          = SQRT_STAGES + CORDIC_LAT;
  localparam int QDEPTH            = 4;

  localparam int CW = 45;  // CORDIC datapath width
  localparam int AW = 20;  // Q16 angle width

  localparam logic [15:0] UPPER_RESET = 16'd7871;
  localparam logic [15:0] LOWER_RESET = 16'd5046;

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  localparam logic signed [AW-1:0] PI_Q16 = 20'sd205887;

  localparam logic signed [AW-1:0] ATAN_Q16 [ATAN_LEN] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
    20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0,
    20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
  };

  // one beat between front and back
  typedef struct packed {
    logic                reach;
    logic [63:0]         pq;
    logic signed [37:0]  n_knee;
    logic signed [37:0]  n_hip;
    logic [35:0]         yz2;
    logic signed [17:0]  x;
    logic signed [17:0]  y;
    logic signed [17:0]  z;
  } mid_t;

  // Q16 -> Q13, round by +4 then floor shift, saturate
  function automatic logic signed [15:0] to_q13(input logic signed [20:0] v);
    logic signed [21:0] t;
    logic signed [18:0] s;
    t = 22'(v) + 22'sd4;
    s = 19'(t >>> 3);
    if (s > 19'sd32767)
      return 16'sh7fff;
    else if (s < -19'sd32768)
      return 16'sh8000;
    else
      return s[15:0];
  endfunction

endpackage

[design/tlik_sqrt.sv]
// Pipelined floor square root of a 64-bit integer, one result bit per stage.
module tlik_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] opnd,
  output logic [31:0] root
);

  localparam int N = tlik_pkg::SQRT_STAGES;

  logic [33:0] rem_r   [N];
  logic [31:0] root_r  [N];
  logic [63:0] opnd_r  [N];
  logic [33:0] rem_nxt [N];
  logic [31:0] root_nxt[N];
  logic [63:0] opnd_nxt[N];

  always_comb begin
    logic [33:0] prem;
    logic [31:0] proot;
    logic [63:0] popnd;
    logic [35:0] acc;
    logic [35:0] trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        prem  = '0;
        proot = '0;
        popnd = opnd;
      end else begin
        prem  = rem_r[k-1];
        proot = root_r[k-1];
        popnd = opnd_r[k-1];
      end
      acc   = {prem, popnd[63:62]};
      trial = {2'b00, proot, 2'b01};
      if (acc >= trial) begin
        rem_nxt[k]  = 34'(acc - trial);
        root_nxt[k] = {proot[30:0], 1'b1};
      end else begin
        rem_nxt[k]  = acc[33:0];
        root_nxt[k] = {proot[30:0], 1'b0};
      end
      opnd_nxt[k] = {popnd[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        opnd_r[k] <= opnd_nxt[k];
      end
    end
  end

  assign root = root_r[N-1];

endmodule

[design/tlik_cordic.sv]
// Pipelined vectoring CORDIC atan2 with quadrant fold and power-of-two normalize.
module tlik_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [tlik_pkg::CW-1:0]  x_in,
  input  logic signed [tlik_pkg::CW-1:0]  y_in,
  output logic signed [tlik_pkg::AW-1:0]  angle
);

  localparam int CW = tlik_pkg::CW;
  localparam int AW = tlik_pkg::AW;
  localparam int NS = tlik_pkg::NORM_STAGES;
  localparam int NI = tlik_pkg::CORDIC_STAGES;

  // index 0 is the fold stage, 1..NS the normalize stages
  logic signed [CW-1:0] nx_r [NS+1];
  logic signed [CW-1:0] ny_r [NS+1];
  logic signed [AW-1:0] nacc_r [NS+1];
  logic [41:0]          nm_r [NS+1];
  logic                 nz_r [NS+1];
  logic signed [CW-1:0] nx_nxt [NS+1];
  logic signed [CW-1:0] ny_nxt [NS+1];
  logic signed [AW-1:0] nacc_nxt [NS+1];
  logic [41:0]          nm_nxt [NS+1];
  logic                 nz_nxt [NS+1];

  logic signed [CW-1:0] ix_r [NI];
  logic signed [CW-1:0] iy_r [NI];
  logic signed [AW-1:0] iacc_r [NI];
  logic                 iz_r [NI];
  logic signed [CW-1:0] ix_nxt [NI];
  logic signed [CW-1:0] iy_nxt [NI];
  logic signed [AW-1:0] iacc_nxt [NI];

  always_comb begin
    logic signed [CW-1:0] x0, y0, ay, px, py, dx, dy;
    logic signed [AW-1:0] pacc;
    logic [41:0]          pm;
    int                   s;
    // fold the left half plane onto the right
    if (x_in < 0) begin
      nacc_nxt[0] = (y_in >= 0) ? tlik_pkg::PI_Q16 : -tlik_pkg::PI_Q16;
      x0 = -x_in;
      y0 = -y_in;
    end else begin
      nacc_nxt[0] = '0;
      x0 = x_in;
      y0 = y_in;
    end
    ay = (y0 < 0) ? -y0 : y0;
    nx_nxt[0] = x0;
    ny_nxt[0] = y0;
    nm_nxt[0] = (x0 > ay) ? x0[41:0] : ay[41:0];
    nz_nxt[0] = (x_in == '0) && (y_in == '0);

    // shift by 32,16,..,1 until the larger magnitude reaches 2^40
    for (int j = 0; j < NS; j++) begin
      s = 32 >> j;
      if (nm_r[j] < (42'd1 << (41 - s))) begin
        nx_nxt[j+1] = nx_r[j] <<< s;
        ny_nxt[j+1] = ny_r[j] <<< s;
        nm_nxt[j+1] = nm_r[j] << s;
      end else begin
        nx_nxt[j+1] = nx_r[j];
        ny_nxt[j+1] = ny_r[j];
        nm_nxt[j+1] = nm_r[j];
      end
      nacc_nxt[j+1] = nacc_r[j];
      nz_nxt[j+1]   = nz_r[j];
    end

    for (int i = 0; i < NI; i++) begin
      if (i == 0) begin
        px   = nx_r[NS];
        py   = ny_r[NS];
        pacc = nacc_r[NS];
      end else begin
        px   = ix_r[i-1];
        py   = iy_r[i-1];
        pacc = iacc_r[i-1];
      end
      dx = py >>> i;
      dy = px >>> i;
      if (py > 0) begin
        ix_nxt[i]   = px + dx;
        iy_nxt[i]   = py - dy;
        iacc_nxt[i] = pacc + tlik_pkg::ATAN_Q16[i];
      end else begin
        ix_nxt[i]   = px - dx;
        iy_nxt[i]   = py + dy;
        iacc_nxt[i] = pacc - tlik_pkg::ATAN_Q16[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= NS; j++) begin
        nx_r[j]   <= nx_nxt[j];
        ny_r[j]   <= ny_nxt[j];
        nacc_r[j] <= nacc_nxt[j];
        nm_r[j]   <= nm_nxt[j];
        nz_r[j]   <= nz_nxt[j];
      end
      for (int i = 0; i < NI; i++) begin
        ix_r[i]   <= ix_nxt[i];
        iy_r[i]   <= iy_nxt[i];
        iacc_r[i] <= iacc_nxt[i];
        iz_r[i]   <= (i == 0) ? nz_r[NS] : iz_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign angle = iz_r[NI-1] ? '0 : iacc_r[NI-1];

endmodule

[design/tlik_front.sv]
// Front end: takes target beats, squares, reach test, Heron product and cosine numerators.
module tlik_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [17:0]    in_target_x,
  input  logic signed [17:0]    in_target_y,
  input  logic signed [17:0]    in_target_z,
  input  logic [15:0]           upper_len,
  input  logic [15:0]           lower_len,
  input  logic                  q_full,
  output logic                  q_push,
  output tlik_pkg::mid_t        q_data
);

  logic en;

  // link terms, refreshed every cycle from the registers
  logic [33:0] sum2_r;
  logic [31:0] diff2_r, l1s_r, l2s_r;

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic signed [17:0] x0_r, y0_r, z0_r, x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [17:0] x3_r, y3_r, z3_r;
  logic [34:0] xsq_r, ysq_r, zsq_r;
  logic [35:0] yz2_r, d2_r, yz3_r;
  logic        reach3_r;
  logic [31:0] p_r, q_r;
  logic signed [37:0] nk3_r, nh3_r;
  tlik_pkg::mid_t out_r;

  logic [16:0]        lsum;
  logic signed [16:0] ldif;
  logic [15:0]        ladif;
  logic signed [35:0] xp, yp, zp;
  logic [35:0]        dp, dq;

  assign lsum  = 17'(upper_len) + 17'(lower_len);
  assign ldif  = $signed({1'b0, upper_len}) - $signed({1'b0, lower_len});
  assign ladif = (ldif < 0) ? 16'(-ldif) : ldif[15:0];

  always_ff @(posedge clk) begin
    sum2_r  <= lsum * lsum;
    diff2_r <= ladif * ladif;
    l1s_r   <= upper_len * upper_len;
    l2s_r   <= lower_len * lower_len;
  end

  assign en       = !(v4_r && q_full);
  assign in_ready = en;
  assign q_push   = v4_r && en;
  assign q_data   = out_r;

  assign xp = x0_r * x0_r;
  assign yp = y0_r * y0_r;
  assign zp = z0_r * z0_r;
  assign dp = d2_r - 36'(diff2_r);
  assign dq = 36'(sum2_r) - d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_target_x;
      y0_r <= in_target_y;
      z0_r <= in_target_z;

      xsq_r <= xp[34:0];
      ysq_r <= yp[34:0];
      zsq_r <= zp[34:0];
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;

      yz2_r <= 36'(ysq_r) + 36'(zsq_r);
      d2_r  <= 36'(xsq_r) + 36'(ysq_r) + 36'(zsq_r);
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;

      // Heron factors only matter when reachable, then both fit in Q30
      reach3_r <= (d2_r <= 36'(sum2_r)) && (d2_r >= 36'(diff2_r));
      p_r      <= dp[33:2];
      q_r      <= dq[33:2];
      nk3_r    <= $signed({6'd0, l1s_r}) + $signed({6'd0, l2s_r}) - $signed({2'd0, d2_r});
      nh3_r    <= $signed({6'd0, l1s_r}) + $signed({2'd0, d2_r}) - $signed({6'd0, l2s_r});
      yz3_r    <= yz2_r;
      x3_r     <= x2_r;
      y3_r     <= y2_r;
      z3_r     <= z2_r;

      out_r.reach  <= reach3_r;
      out_r.pq     <= p_r * q_r;
      out_r.n_knee <= nk3_r;
      out_r.n_hip  <= nh3_r;
      out_r.yz2    <= yz3_r;
      out_r.x      <= x3_r;
      out_r.y      <= y3_r;
      out_r.z      <= z3_r;
    end
  end

endmodule

[design/tlik_queue.sv]
// Short FIFO between front and back ends.
`include "two_link_leg_inverse_kinematics_assert.svh"
module tlik_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tlik_pkg::mid_t  push_data,
  output logic            full,
  input  logic            pop,
  output tlik_pkg::mid_t  head,
  output logic            empty
);

  localparam int D  = tlik_pkg::QDEPTH;
  localparam int PW = $clog2(D);
  localparam int CNW = $clog2(D + 1);

  tlik_pkg::mid_t mem_r [D];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CNW-1:0] cnt_r;

  assign full  = (cnt_r == CNW'(D));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= PW'((32'(wr_r) + 1) % D);
      if (pop)  rd_r <= PW'((32'(rd_r) + 1) % D);
      cnt_r <= CNW'(32'(cnt_r) + 32'(push) - 32'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  `TLIK_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into full queue")
  `TLIK_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !empty, "pop from empty queue")
  `TLIK_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNW'(D), "queue count out of range")
  `TLIK_ASSERT(a_cnt_track, clk, rst_n, ##1 cnt_r == CNW'(32'($past(cnt_r)) + 32'($past(push)) - 32'($past(pop))), "queue count lost a beat")

endmodule

[design/tlik_back.sv]
// Back end: square roots, four CORDIC atan2 pipes and the result register.
module tlik_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tlik_pkg::mid_t      head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_reachable,
  output logic signed [15:0]  out_roll_angle,
  output logic signed [15:0]  out_pitch_angle,
  output logic signed [15:0]  out_knee_angle
);

  localparam int CW = tlik_pkg::CW;
  localparam int AW = tlik_pkg::AW;
  localparam int SQ = tlik_pkg::SQRT_STAGES;
  localparam int CL = tlik_pkg::CORDIC_LAT;
  localparam int BL = tlik_pkg::BACK_LAT;

  typedef struct packed {
    logic               reach;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic signed [37:0] n_knee;
    logic signed [37:0] n_hip;
  } side_t;

  logic  en;
  logic  vld_r [BL];
  side_t sd_r  [SQ];
  logic  rch_r [CL];
  logic  out_valid_r;

  logic [31:0] root_pq, root_yz;
  logic signed [CW-1:0] rx, ry, ax, ay, area4, bx, gx;
  logic signed [AW-1:0] roll_a, alpha_a, beta_a, gamma_a;
  logic signed [20:0]   pitch_w, knee_w;

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && !empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BL; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !empty;
      for (int k = 1; k < BL; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[BL-1];
    end
  end

  tlik_sqrt u_sqrt_pq (
    .clk  (clk),
    .en   (en),
    .opnd (head.pq),
    .root (root_pq)
  );

  tlik_sqrt u_sqrt_yz (
    .clk  (clk),
    .en   (en),
    .opnd ({8'd0, head.yz2, 20'd0}),
    .root (root_yz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0].reach  <= head.reach;
      sd_r[0].x      <= head.x;
      sd_r[0].y      <= head.y;
      sd_r[0].z      <= head.z;
      sd_r[0].n_knee <= head.n_knee;
      sd_r[0].n_hip  <= head.n_hip;
      for (int k = 1; k < SQ; k++) sd_r[k] <= sd_r[k-1];
      rch_r[0] <= sd_r[SQ-1].reach;
      for (int k = 1; k < CL; k++) rch_r[k] <= rch_r[k-1];
    end
  end

  // roll: atan2(y, -z); alpha: atan2(sqrt(y^2+z^2) Q26, x Q26)
  assign ry    = CW'(sd_r[SQ-1].y);
  assign rx    = -CW'(sd_r[SQ-1].z);
  assign ay    = $signed({17'd0, root_yz[27:0]});
  assign ax    = CW'(sd_r[SQ-1].x) <<< 10;
  assign area4 = $signed({11'd0, root_pq, 2'b00});
  assign bx    = CW'(sd_r[SQ-1].n_hip);
  assign gx    = CW'(sd_r[SQ-1].n_knee);

  tlik_cordic u_roll  (.clk(clk), .en(en), .x_in(rx), .y_in(ry),    .angle(roll_a));
  tlik_cordic u_alpha (.clk(clk), .en(en), .x_in(ax), .y_in(ay),    .angle(alpha_a));
  tlik_cordic u_beta  (.clk(clk), .en(en), .x_in(bx), .y_in(area4), .angle(beta_a));
  tlik_cordic u_gamma (.clk(clk), .en(en), .x_in(gx), .y_in(area4), .angle(gamma_a));

  assign pitch_w = 21'(alpha_a) - 21'(beta_a);
  assign knee_w  = 21'(tlik_pkg::PI_Q16) - 21'(gamma_a);

  always_ff @(posedge clk) begin
    if (en) begin
      out_reachable   <= rch_r[CL-1];
      out_roll_angle  <= tlik_pkg::to_q13(21'(roll_a));
      out_pitch_angle <= rch_r[CL-1] ? tlik_pkg::to_q13(pitch_w) : '0;
      out_knee_angle  <= rch_r[CL-1] ? tlik_pkg::to_q13(knee_w) : '0;
    end
  end

endmodule

[design/two_link_leg_inverse_kinematics.sv]
// Leg inverse kinematics top level: APB registers, front end, queue, back end.
// Turns a Q16 foot target into Q13 hip roll, hip pitch and knee angles, one beat per
// clock sustained while the result side accepts. A beat passes through the front end
// (squares, reach test, Heron product), the queue, the pipelined square roots, the
// CORDIC pipes (fold, six normalize shifts, 16 rotations) and the result register.
// The queue lets the front end keep taking beats while the result side is stalled,
// until it fills. Link lengths sit at byte addresses 0 and 4 and may be changed only
// while the block is empty.
module two_link_leg_inverse_kinematics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] in_target_x,
  input  logic signed [17:0] in_target_y,
  input  logic signed [17:0] in_target_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reachable,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_knee_angle
);

  logic [15:0] upper_r, lower_r;
  logic        q_push, q_full, q_pop, q_empty;
  tlik_pkg::mid_t q_in, q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= tlik_pkg::UPPER_RESET;
      lower_r <= tlik_pkg::LOWER_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tlik_pkg::REG_UPPER: upper_r <= pwdata[15:0];
        tlik_pkg::REG_LOWER: lower_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tlik_pkg::REG_UPPER: prdata = {16'd0, upper_r};
      tlik_pkg::REG_LOWER: prdata = {16'd0, lower_r};
      default:             prdata = '0;
    endcase
  end

  tlik_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_target_z (in_target_z),
    .upper_len   (upper_r),
    .lower_len   (lower_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  tlik_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  tlik_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reachable   (out_reachable),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_knee_angle  (out_knee_angle)
  );

endmodule

[test/tb_two_link_leg_inverse_kinematics.sv]
// Testbench for the leg inverse kinematics block: directed table, random targets, scoreboard.
module tb_two_link_leg_inverse_kinematics;

  typedef struct packed {
    logic               reach;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] knee;
  } angles_t;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic               typed;
    angles_t            want;
  } target_row_t;

  localparam int      ROW_CNT     = 19;
  localparam int      RAND_ITEMS  = 240;
  localparam int      WDOG_LIMIT  = 20000;
  localparam int      SETTLE      = 80;
  localparam longint  PI_FIX      = 205887;
  localparam angles_t ALL_ZERO    = '{1'b0, 16'sd0, 16'sd0, 16'sd0};
  localparam logic [2:0] ADDR_UPPER = {tlik_pkg::REG_UPPER, 2'b00};
  localparam logic [2:0] ADDR_LOWER = {tlik_pkg::REG_LOWER, 2'b00};

  localparam longint ARCTAN_Q16 [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
  };

  // default links: outer reach 12917, inner reach 2825
  localparam target_row_t TARGET_ROWS [ROW_CNT] = '{
    '{18'sd0, 18'sd0, 18'sd0, 1'b1, ALL_ZERO},
    '{18'sd131071, 18'sd0, 18'sd0, 1'b1, ALL_ZERO},
    '{-18'sd131072, 18'sd0, 18'sd0, 1'b1, ALL_ZERO},
    '{18'sd0, 18'sd131071, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd0, -18'sd131072, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd0, 18'sd0, 18'sd131071, 1'b0, ALL_ZERO},
    '{18'sd0, 18'sd0, -18'sd131072, 1'b0, ALL_ZERO},
    '{18'sd12917, 18'sd0, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd2825, 18'sd0, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd12918, 18'sd0, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd2824, 18'sd0, 18'sd0, 1'b0, ALL_ZERO},
    '{18'sd0, 18'sd0, -18'sd10000, 1'b0, ALL_ZERO},
    '{18'sd0, 18'sd0, 18'sd10000, 1'b0, ALL_ZERO},
    '{-18'sd8000, 18'sd0, -18'sd6000, 1'b0, ALL_ZERO},
    '{18'sd3000, 18'sd4000, -18'sd8000, 1'b0, ALL_ZERO},
    '{-18'sd12000, 18'sd0, 18'sd1000, 1'b0, ALL_ZERO},
    '{18'sd0, -18'sd5000, -18'sd9000, 1'b0, ALL_ZERO},
    '{18'sd131071, 18'sd131071, 18'sd131071, 1'b0, ALL_ZERO},
    '{-18'sd131072, -18'sd131072, -18'sd131072, 1'b0, ALL_ZERO}
  };

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic signed [17:0] in_target_x;
  logic signed [17:0] in_target_y;
  logic signed [17:0] in_target_z;
  logic               out_valid;
  logic               out_ready;
  logic               out_reachable;
  logic signed [15:0] out_roll_angle;
  logic signed [15:0] out_pitch_angle;
  logic signed [15:0] out_knee_angle;

  logic [15:0] upper_len;
  logic [15:0] lower_len;
  angles_t     pending_angles [$];
  int          mismatches;
  int          targets_sent;
  int          results_seen;
  int          reach_seen;
  int          settings_run;
  int          quiet_cycles;
  bit          no_idle;
  bit          hold_req;

  two_link_leg_inverse_kinematics u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_target_x     (in_target_x),
    .in_target_y     (in_target_y),
    .in_target_z     (in_target_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reachable   (out_reachable),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_knee_angle  (out_knee_angle)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v)
      b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, Q16 radians out
  function automatic longint vector_angle(longint yv, longint xv);
    longint          acc;
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned m;
    acc = 0;
    if (xv == 0 && yv == 0)
      return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? PI_FIX : -PI_FIX;
      xv = -xv;
      yv = -yv;
    end
    ax = (xv < 0) ? -xv : xv;
    ay = (yv < 0) ? -yv : yv;
    m = (ax > ay) ? ax : ay;
    while (m < (64'd1 << 40)) begin
      xv *= 2;
      yv *= 2;
      m <<= 1;
    end
    for (int i = 0; i < tlik_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx;
        yv -= dy;
        acc += ARCTAN_Q16[i];
      end else begin
        xv -= dx;
        yv += dy;
        acc -= ARCTAN_Q16[i];
      end
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] q16_to_q13(longint v);
    longint t;
    t = (v + 4) >>> 3;
    if (t > 32767)
      t = 32767;
    if (t < -32768)
      t = -32768;
    return t[15:0];
  endfunction

  function automatic bit within_reach(longint x, longint y, longint z);
    longint d2;
    longint l1;
    longint l2;
    l1 = upper_len;
    l2 = lower_len;
    d2 = x * x + y * y + z * z;
    return d2 <= (l1 + l2) * (l1 + l2) && d2 >= (l1 - l2) * (l1 - l2);
  endfunction

  function automatic angles_t leg_angles(logic signed [17:0] tx, logic signed [17:0] ty,
                                          logic signed [17:0] tz);
    angles_t         a;
    longint          x;
    longint          y;
    longint          z;
    longint          l1;
    longint          l2;
    longint          yz2;
    longint          d2;
    longint          sum2;
    longint          diff2;
    longint unsigned p;
    longint unsigned q;
    longint          area4;
    longint          n_knee;
    longint          n_hip;
    longint          zproj;
    x = tx;
    y = ty;
    z = tz;
    l1 = upper_len;
    l2 = lower_len;
    yz2 = y * y + z * z;
    d2 = x * x + yz2;
    sum2 = (l1 + l2) * (l1 + l2);
    diff2 = (l1 - l2) * (l1 - l2);
    a = ALL_ZERO;
    a.roll = q16_to_q13(vector_angle(y, -z));
    if (d2 > sum2 || d2 < diff2)
      return a;
    p = longint'(d2 - diff2) >> 2;
    q = longint'(sum2 - d2) >> 2;
    area4 = longint'(floor_sqrt(p * q)) * 4;
    n_knee = l1 * l1 + l2 * l2 - d2;
    n_hip = l1 * l1 + d2 - l2 * l2;
    zproj = longint'(floor_sqrt(longint'(yz2) << 20));
    a.reach = 1'b1;
    a.pitch = q16_to_q13(vector_angle(zproj, x * 1024) - vector_angle(area4, n_hip));
    a.knee = q16_to_q13(PI_FIX - vector_angle(area4, n_knee));
    return a;
  endfunction

  task automatic write_link(logic [2:0] addr, logic [15:0] len);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, len};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_UPPER)
      upper_len = len;
    else
      lower_len = len;
  endtask

  task automatic offer_target(logic signed [17:0] x, logic signed [17:0] y,
                              logic signed [17:0] z, logic typed, angles_t want);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_target_x <= x;
    in_target_y <= y;
    in_target_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_angles.push_back(typed ? want : leg_angles(x, y, z));
    targets_sent++;
  endtask

  // wait until every result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_targets(int count, int hold_at, int pause_at);
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    int                 span;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at)
        hold_req = 1'b1;
      if (n == pause_at)
        drain_results();
      if ($urandom_range(99) < 75) begin
        // mostly targets inside the reach annulus
        span = upper_len + lower_len;
        if (span > 131071)
          span = 131071;
        for (int t = 0; t < 20; t++) begin
          x = 18'($urandom_range(2 * span) - span);
          y = 18'($urandom_range(2 * span) - span);
          z = 18'($urandom_range(2 * span) - span);
          if (within_reach(x, y, z))
            break;
        end
      end else begin
        x = 18'($urandom);
        y = 18'($urandom);
        z = 18'($urandom);
      end
      offer_target(x, y, z, 1'b0, ALL_ZERO);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_reachable)
        reach_seen++;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: reach=%0b roll=%0d", out_reachable, out_roll_angle);
      end else begin
        angles_t e;
        e = pending_angles.pop_front();
        if (e.reach !== out_reachable || e.roll !== out_roll_angle ||
            e.pitch !== out_pitch_angle || e.knee !== out_knee_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp reach=%0b roll=%0d pitch=%0d knee=%0d, got %0b %0d %0d %0d",
                     e.reach, e.roll, e.pitch, e.knee, out_reachable, out_roll_angle,
                     out_pitch_angle, out_knee_angle);
        end
      end
    end
  end

  // result side: random stalls, quiet stretch, one long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] link_pairs [7][2];
    link_pairs = '{'{16'd65535, 16'd65535}, '{16'd0, 16'd0}, '{16'd65535, 16'd0},
                   '{16'd0, 16'd65535}, '{16'd12000, 16'd3000},
                   '{16'($urandom), 16'($urandom)},
                   '{tlik_pkg::UPPER_RESET, tlik_pkg::LOWER_RESET}};
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_target_x  = '0;
    in_target_y  = '0;
    in_target_z  = '0;
    upper_len    = tlik_pkg::UPPER_RESET;
    lower_len    = tlik_pkg::LOWER_RESET;
    mismatches   = 0;
    targets_sent = 0;
    results_seen = 0;
    reach_seen   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    settings_run = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (TARGET_ROWS[i])
      offer_target(TARGET_ROWS[i].x, TARGET_ROWS[i].y, TARGET_ROWS[i].z,
                   TARGET_ROWS[i].typed, TARGET_ROWS[i].want);
    random_targets(RAND_ITEMS, 120, -1);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      write_link(ADDR_UPPER, link_pairs[ph][0]);
      write_link(ADDR_LOWER, link_pairs[ph][1]);
      settings_run++;
      no_idle = (ph == 0);
      random_targets(RAND_ITEMS, -1, (ph == 2) ? RAND_ITEMS / 2 : -1);
      drain_results();
    end

    $display("%0d targets over %0d link settings; %0d results checked, %0d reachable",
             targets_sent, settings_run, results_seen, reach_seen);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tlik_pkg.sv
design/tlik_sqrt.sv
design/tlik_cordic.sv
design/tlik_front.sv
design/tlik_queue.sv
design/tlik_back.sv
design/two_link_leg_inverse_kinematics.sv
test/tb_two_link_leg_inverse_kinematics.sv
